// File: src/utz_pkg.sv
package utz_pkg;

  localparam int unsigned YEAR_W   = 8;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;
  localparam int unsigned ZONE_W   = 4;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ZONE_W-1:0]  ZONE_MAX      = 4'd12;
  localparam logic [ZONE_W-1:0]  ZONE_RESET    = 4'd8;
  localparam logic               EAST_RESET    = 1'b1;
  localparam logic [HOUR_W:0]    HOURS_PER_DAY = 6'd24;
  localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;

  // years after 2000 that are centuries but not multiples of 400
  localparam logic [YEAR_W-1:0]  YEAR_2100     = 8'd100;
  localparam logic [YEAR_W-1:0]  YEAR_2200     = 8'd200;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_HOURS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EAST_ZONE  = 1'b1;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } stamp_t;

  // gregorian rule over 2000..2255
  function automatic logic is_leap(input logic [YEAR_W-1:0] yy);
    is_leap = (yy[1:0] == 2'b00) && (yy != YEAR_2100) && (yy != YEAR_2200);
  endfunction

  // month length, zero for a month code outside 1..12
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                  input logic [YEAR_W-1:0]  yy);
    case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_days = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_days = 5'd30;
      4'd2:    month_days = is_leap(yy) ? 5'd29 : 5'd28;
      default: month_days = 5'd0;
    endcase
  endfunction

endpackage

// File: src/utz_calc.sv
module utz_calc import utz_pkg::*; (
  input  stamp_t            stamp_i,
  input  logic [ZONE_W-1:0] zone_hours_i,
  input  logic              east_zone_i,
  output stamp_t            stamp_o
);

  logic [HOUR_W:0]    hour_sum;
  logic [HOUR_W:0]    hour_wrap;
  logic               month_ok;
  logic [MONTH_W-1:0] prev_month;
  logic [YEAR_W-1:0]  prev_year;

  always_comb begin
    stamp_o    = stamp_i;
    month_ok   = (stamp_i.month >= MONTH_JAN) && (stamp_i.month <= MONTH_DEC);
    hour_sum   = {1'b0, stamp_i.hour} + {2'b00, zone_hours_i};
    hour_wrap  = {1'b0, stamp_i.hour} + HOURS_PER_DAY - {2'b00, zone_hours_i};
    prev_month = (stamp_i.month == MONTH_JAN) ? MONTH_DEC : stamp_i.month - 4'd1;
    prev_year  = (stamp_i.month == MONTH_JAN) ? stamp_i.year - 8'd1 : stamp_i.year;

    if ((zone_hours_i != '0) && (zone_hours_i <= ZONE_MAX)) begin
      if (east_zone_i) begin
        if (hour_sum < HOURS_PER_DAY) begin
          stamp_o.hour = hour_sum[HOUR_W-1:0];
        end else begin
          stamp_o.hour = HOUR_W'(hour_sum - HOURS_PER_DAY);
          if (month_ok) begin
            if (stamp_i.day >= month_days(stamp_i.month, stamp_i.year)) begin
              stamp_o.day = DAY_FIRST;
              if (stamp_i.month == MONTH_DEC) begin
                stamp_o.month = MONTH_JAN;
                stamp_o.year  = stamp_i.year + 8'd1;
              end else begin
                stamp_o.month = stamp_i.month + 4'd1;
              end
            end else begin
              stamp_o.day = stamp_i.day + 5'd1;
            end
          end
        end
      end else begin
        if (stamp_i.hour >= {1'b0, zone_hours_i}) begin
          stamp_o.hour = stamp_i.hour - {1'b0, zone_hours_i};
        end else begin
          stamp_o.hour = hour_wrap[HOUR_W-1:0];
          if (month_ok) begin
            if (stamp_i.day <= DAY_FIRST) begin
              stamp_o.month = prev_month;
              stamp_o.year  = prev_year;
              stamp_o.day   = month_days(prev_month, prev_year);
            end else begin
              stamp_o.day = stamp_i.day - 5'd1;
            end
          end
        end
      end
    end
  end

endmodule

// File: src/utc_time_zone_shift.sv
// channel   direction  handshake              payload
// in        sink       in_valid_i/in_stall_o   in_year_i .. in_second_i
// out       source     out_valid_o/out_stall_i out_year_o .. out_second_o
// cfg       sink       cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// two register stages: an input register, then the calendar logic, then the
// result register, which a beat reaches from the input register once advance allows it
// one beat per cycle sustained while the output is not stalled; the calendar path is combinational
// rst_ni clears both valid flags and loads the zone registers (8 h, east)
// a stall on the output holds the result register; the input register still
// takes a beat while it is empty or the result register is free or being emptied
module utc_time_zone_shift import utz_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [YEAR_W-1:0]    in_year_i,
  input  logic [MONTH_W-1:0]   in_month_i,
  input  logic [DAY_W-1:0]     in_day_i,
  input  logic [HOUR_W-1:0]    in_hour_i,
  input  logic [MINUTE_W-1:0]  in_minute_i,
  input  logic [SECOND_W-1:0]  in_second_i,

  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [YEAR_W-1:0]    out_year_o,
  output logic [MONTH_W-1:0]   out_month_o,
  output logic [DAY_W-1:0]     out_day_o,
  output logic [HOUR_W-1:0]    out_hour_o,
  output logic [MINUTE_W-1:0]  out_minute_o,
  output logic [SECOND_W-1:0]  out_second_o,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // zone configuration
  logic [ZONE_W-1:0] zone_hours_q;
  logic              east_zone_q;

  // input register
  logic   in_valid_q;
  stamp_t in_stamp_q;

  // result register
  logic   out_valid_q;
  stamp_t out_stamp_q;
  stamp_t out_stamp_d;

  logic advance;  // result register can load this cycle
  logic in_take;  // input beat accepted

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_hours_q <= ZONE_RESET;
      east_zone_q  <= EAST_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ZONE_HOURS: zone_hours_q <= cfg_wdata_i[ZONE_W-1:0];
        CFG_EAST_ZONE:  east_zone_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // the result register empties when it is taken downstream
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance || !in_valid_q) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_stamp_q <= '{year:   in_year_i,   month:  in_month_i,
                      day:    in_day_i,    hour:   in_hour_i,
                      minute: in_minute_i, second: in_second_i};
    end
  end

  // hour shift with day, month and year carry or borrow
  utz_calc u_calc (
    .stamp_i      (in_stamp_q),
    .zone_hours_i (zone_hours_q),
    .east_zone_i  (east_zone_q),
    .stamp_o      (out_stamp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_stamp_q <= out_stamp_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_year_o   = out_stamp_q.year;
  assign out_month_o  = out_stamp_q.month;
  assign out_day_o    = out_stamp_q.day;
  assign out_hour_o   = out_stamp_q.hour;
  assign out_minute_o = out_stamp_q.minute;
  assign out_second_o = out_stamp_q.second;

  // an accepted beat always lands in the input register
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted beat not held in input register");

  // a held beat in the input register is not dropped while stalled
  a_held_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q)
    else $error("stalled input beat lost");

  // an empty input register never back-pressures
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

  // minute and second pass through the calendar logic untouched
  a_passthrough: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q) |=>
      (out_minute_o == $past(in_stamp_q.minute)) &&
      (out_second_o == $past(in_stamp_q.second)))
    else $error("minute or second altered");

endmodule
